[hw/rtl/ierm_pkg.sv]
package ierm_pkg;

	// command codes
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_TICK  = 2'd1;
	localparam logic [1:0] CMD_BYTE  = 2'd2;

	// result status codes
	localparam logic [1:0] STATUS_MATCH   = 2'd0;
	localparam logic [1:0] STATUS_TIMEOUT = 2'd1;
	localparam logic [1:0] STATUS_SKIP    = 2'd2;

	// register map indexes
	localparam logic [1:0] REG_IDENTIFIER = 2'd0;
	localparam logic [1:0] REG_SEQUENCE   = 2'd1;
	localparam logic [1:0] REG_SOURCE     = 2'd2;
	localparam logic [1:0] REG_TIMEOUT    = 2'd3;

	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;
	localparam int RTT_W     = 24;
	localparam int TIMEOUT_W = 24;

	// packet framing constants
	localparam logic [5:0] MIN_HEADER = 6'd20;
	localparam logic [6:0] ICMP_LEAD  = 7'd8;
	localparam logic [6:0] POS_MAX    = 7'd127;
	localparam logic [7:0] ECHO_REPLY = 8'd0;
	localparam logic [6:0] SRC_FIRST  = 7'd12;
	localparam logic [6:0] SRC_LAST   = 7'd15;

	localparam logic [15:0]          RST_IDENTIFIER = 16'd0;
	localparam logic [15:0]          RST_SEQUENCE   = 16'd1;
	localparam logic [31:0]          RST_SOURCE     = 32'd0;
	localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT    = 24'd1000;

	typedef struct packed {
		logic [15:0]          match_identifier;
		logic [15:0]          match_sequence;
		logic [31:0]          match_source;
		logic [TIMEOUT_W-1:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic last;
		logic ok;
	} pkt_check_t;

endpackage

[hw/rtl/ierm_ifs.sv]
interface ierm_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] packet_byte;
	logic       end_of_packet;

	modport source (output valid, output cmd, output packet_byte, output end_of_packet,
		input ready);
	modport sink (input valid, input cmd, input packet_byte, input end_of_packet,
		output ready);
endinterface

interface ierm_res_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                status;
	logic [ierm_pkg::RTT_W-1:0] round_trip_ticks;

	modport source (output valid, output status, output round_trip_ticks, input ready);
	modport sink (input valid, input status, input round_trip_ticks, output ready);
endinterface

[hw/rtl/icmp_echo_reply_matcher.sv]
// path: a command transfer loads the input register; its result (if any) goes from there
// into the result register, from which it is taken
// throughput: one command per cycle; the input stalls only while a result is pending
// and the result register still holds an untaken result
// reset: arst_n clears the armed flag, tick count, packet framing state and both
// pipeline valids, and sets the configuration registers to their reset values
module icmp_echo_reply_matcher #(
	parameter int COUNT_WIDTH = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	ierm_cmd_if.sink                    cmd_ch,
	ierm_res_if.source                  res_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ierm_pkg::ADDR_W-1:0] paddr,
	input  logic [ierm_pkg::DATA_W-1:0] pwdata,
	output logic [ierm_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);

	// compare width covers both the tick count and the timeout register
	localparam int CMP_W = (COUNT_WIDTH > ierm_pkg::RTT_W) ? COUNT_WIDTH : ierm_pkg::RTT_W;

	ierm_pkg::cfg_t       cfg;
	ierm_pkg::pkt_check_t chk;

	// input register stage
	logic       valid_s1;
	logic [1:0] cmd_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// block state
	logic                   waiting_q;
	logic [COUNT_WIDTH-1:0] elapsed_q;

	// result register
	logic                        res_valid_q;
	logic [1:0]                  res_status_q;
	logic [ierm_pkg::RTT_W-1:0]  res_rtt_q;

	logic [COUNT_WIDTH-1:0] elapsed_inc;
	logic [CMP_W-1:0]       inc_ext;
	logic [CMP_W-1:0]       cur_ext;
	logic [CMP_W-1:0]       tmo_ext;
	logic                   tick_fire;
	logic                   pkt_fire;
	logic                   s1_has_res;
	logic                   out_free;
	logic                   s1_go;
	logic                   byte_en;

	ierm_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// packet framing and field capture, stepped once per packet byte
	ierm_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (byte_en),
		.packet_byte   (byte_s1),
		.end_of_packet (last_s1),
		.cfg           (cfg),
		.chk           (chk)
	);

	// saturating tick count
	assign elapsed_inc = (elapsed_q == {COUNT_WIDTH{1'b1}}) ? elapsed_q
		: elapsed_q + COUNT_WIDTH'(1);
	assign inc_ext = CMP_W'(elapsed_inc);
	assign cur_ext = CMP_W'(elapsed_q);
	assign tmo_ext = CMP_W'(cfg.timeout_ticks);

	// which staged commands produce a result
	assign tick_fire  = (cmd_s1 == ierm_pkg::CMD_TICK) && waiting_q && (inc_ext >= tmo_ext);
	assign pkt_fire   = (cmd_s1 == ierm_pkg::CMD_BYTE) && chk.last && waiting_q;
	assign s1_has_res = tick_fire || pkt_fire;

	// the staged command moves on unless it has a result and the result slot is busy
	assign out_free = !res_valid_q || res_ch.ready;
	assign s1_go    = valid_s1 && (!s1_has_res || out_free);
	assign byte_en  = s1_go && (cmd_s1 == ierm_pkg::CMD_BYTE);

	assign cmd_ch.ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ch.ready) begin
			valid_s1 <= cmd_ch.valid;
		end
	end

	// payload of the input stage, loaded on every transfer
	always_ff @(posedge clk) begin
		if (cmd_ch.valid && cmd_ch.ready) begin
			cmd_s1  <= cmd_ch.cmd;
			byte_s1 <= cmd_ch.packet_byte;
			last_s1 <= cmd_ch.end_of_packet;
		end
	end

	// armed flag and tick count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q <= 1'b0;
			elapsed_q <= '0;
		end else if (s1_go) begin
			case (cmd_s1)
				ierm_pkg::CMD_START: begin
					waiting_q <= 1'b1;
					elapsed_q <= '0;
				end
				ierm_pkg::CMD_TICK: begin
					if (waiting_q) begin
						elapsed_q <= elapsed_inc;
					end
					if (tick_fire) begin
						waiting_q <= 1'b0;
					end
				end
				ierm_pkg::CMD_BYTE: begin
					// a match disarms, a skipped packet keeps waiting
					if (pkt_fire && chk.ok) begin
						waiting_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_go && s1_has_res) begin
			res_valid_q <= 1'b1;
		end else if (res_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload: a timeout reports the count after this tick
	always_ff @(posedge clk) begin
		if (s1_go && s1_has_res) begin
			if (tick_fire) begin
				res_status_q <= ierm_pkg::STATUS_TIMEOUT;
				res_rtt_q    <= inc_ext[ierm_pkg::RTT_W-1:0];
			end else begin
				res_status_q <= chk.ok ? ierm_pkg::STATUS_MATCH : ierm_pkg::STATUS_SKIP;
				res_rtt_q    <= cur_ext[ierm_pkg::RTT_W-1:0];
			end
		end
	end

	assign res_ch.valid            = res_valid_q;
	assign res_ch.status           = res_status_q;
	assign res_ch.round_trip_ticks = res_rtt_q;

endmodule

[hw/rtl/ierm_apb_regs.sv]
module ierm_apb_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ierm_pkg::ADDR_W-1:0] paddr,
	input  logic [ierm_pkg::DATA_W-1:0] pwdata,
	output logic [ierm_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output ierm_pkg::cfg_t              cfg
);

	ierm_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [1:0]     reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.match_identifier <= ierm_pkg::RST_IDENTIFIER;
			cfg_q.match_sequence   <= ierm_pkg::RST_SEQUENCE;
			cfg_q.match_source     <= ierm_pkg::RST_SOURCE;
			cfg_q.timeout_ticks    <= ierm_pkg::RST_TIMEOUT;
		end else if (wr_en) begin
			case (reg_idx)
				ierm_pkg::REG_IDENTIFIER: cfg_q.match_identifier <= pwdata[15:0];
				ierm_pkg::REG_SEQUENCE:   cfg_q.match_sequence   <= pwdata[15:0];
				ierm_pkg::REG_SOURCE:     cfg_q.match_source     <= pwdata;
				ierm_pkg::REG_TIMEOUT:
					cfg_q.timeout_ticks <= pwdata[ierm_pkg::TIMEOUT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			ierm_pkg::REG_IDENTIFIER: prdata = {16'd0, cfg_q.match_identifier};
			ierm_pkg::REG_SEQUENCE:   prdata = {16'd0, cfg_q.match_sequence};
			ierm_pkg::REG_SOURCE:     prdata = cfg_q.match_source;
			ierm_pkg::REG_TIMEOUT:
				prdata = {{(ierm_pkg::DATA_W - ierm_pkg::TIMEOUT_W){1'b0}},
					cfg_q.timeout_ticks};
			default:                  prdata = '0;
		endcase
	end

endmodule

[hw/rtl/ierm_parser.sv]
module ierm_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic [7:0]             packet_byte,
	input  logic                   end_of_packet,
	input  ierm_pkg::cfg_t         cfg,
	output ierm_pkg::pkt_check_t   chk
);

	logic [6:0]  pos_q;
	logic [5:0]  hdr_q;
	logic [31:0] src_q;
	logic [7:0]  typ_q;
	logic [15:0] id_q;
	logic [15:0] seq_q;

	logic [6:0]  pos_inc;
	logic [6:0]  hdr_ext;
	logic [5:0]  hdr_d;
	logic [31:0] src_d;
	logic [7:0]  typ_d;
	logic [15:0] id_d;
	logic [15:0] seq_d;

	assign hdr_ext = {1'b0, hdr_q};
	assign pos_inc = (pos_q == ierm_pkg::POS_MAX) ? pos_q : pos_q + 7'd1;

	// capture of header length, source address and echo fields
	always_comb begin
		hdr_d = hdr_q;
		src_d = src_q;
		typ_d = typ_q;
		id_d  = id_q;
		seq_d = seq_q;
		if (pos_q == 7'd0) begin
			hdr_d = {packet_byte[3:0], 2'b00};
		end else if (pos_q >= ierm_pkg::SRC_FIRST && pos_q <= ierm_pkg::SRC_LAST) begin
			src_d = {src_q[23:0], packet_byte};
		end
		if (pos_q != 7'd0) begin
			if (pos_q == hdr_ext) begin
				typ_d = packet_byte;
			end else if (pos_q == hdr_ext + 7'd4) begin
				id_d = {packet_byte, id_q[7:0]};
			end else if (pos_q == hdr_ext + 7'd5) begin
				id_d = {id_q[15:8], packet_byte};
			end else if (pos_q == hdr_ext + 7'd6) begin
				seq_d = {packet_byte, seq_q[7:0]};
			end else if (pos_q == hdr_ext + 7'd7) begin
				seq_d = {seq_q[15:8], packet_byte};
			end
		end
	end

	assign chk.last = end_of_packet;
	assign chk.ok   = (hdr_d >= ierm_pkg::MIN_HEADER)
		&& (pos_inc >= {1'b0, hdr_d} + ierm_pkg::ICMP_LEAD)
		&& (typ_d == ierm_pkg::ECHO_REPLY)
		&& (id_d == cfg.match_identifier)
		&& (seq_d == cfg.match_sequence)
		&& (src_d == cfg.match_source);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			hdr_q <= '0;
			src_q <= '0;
			typ_q <= '0;
			id_q  <= '0;
			seq_q <= '0;
		end else if (en) begin
			pos_q <= end_of_packet ? 7'd0 : pos_inc;
			hdr_q <= hdr_d;
			src_q <= src_d;
			typ_q <= typ_d;
			id_q  <= id_d;
			seq_q <= seq_d;
		end
	end

endmodule

[hw/rtl/ierm_checker.sv]
module ierm_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cmd_ready,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic [1:0]                 res_status,
	input logic [ierm_pkg::RTT_W-1:0] res_rtt
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_status) && $stable(res_rtt))
		else $error("result changed while stalled");

	// only defined status codes leave the block
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_status == ierm_pkg::STATUS_MATCH
			|| res_status == ierm_pkg::STATUS_TIMEOUT
			|| res_status == ierm_pkg::STATUS_SKIP))
		else $error("undefined status code");

	// the input side only stalls behind a result that is not taken
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> res_valid && !res_ready)
		else $error("input stalled without output backpressure");

	// reset empties the result register
	a_reset_clear: assert property (@(posedge clk)
		!arst_n |-> !res_valid)
		else $error("result valid during reset");

	// a result never rises directly out of reset
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> !$past(!arst_n))
		else $error("result right after reset");

endmodule

bind icmp_echo_reply_matcher ierm_checker u_ierm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_ready  (cmd_ch.ready),
	.res_valid  (res_ch.valid),
	.res_ready  (res_ch.ready),
	.res_status (res_ch.status),
	.res_rtt    (res_ch.round_trip_ticks)
);
